@@ rtl/core/mmr_pkg.sv @@
package mmr_pkg;

  // Fixed field widths of the item, result and configuration ports and of the products.
  localparam int KIND_W    = 2;
  localparam int ROW_W     = 3;
  localparam int VALUE_W   = 16;
  localparam int MUL_W     = 32;
  localparam int PRODUCT_W = 40;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_e_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_ROW = 2'd0,
    CFG_END_ROW   = 2'd1
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STREAM,
    ST_WAIT,
    ST_EMIT
  } state_t;

  // Control flags that travel down the cell chain with each A element.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tok_t;

endpackage

@@ rtl/core/mmr_ram.sv @@
module mmr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/mmr_cell.sv @@
module mmr_cell #(
  parameter int DIM = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Load of one element of this cell's column of B.
  input  logic                                  b_we,
  input  logic [$clog2(DIM)-1:0]                b_row,
  input  logic signed [mmr_pkg::VALUE_W-1:0]    b_value,
  // A element stream from the previous cell.
  input  mmr_pkg::tok_t                         tok_in,
  input  logic [$clog2(DIM)-1:0]                k_in,
  input  logic signed [mmr_pkg::VALUE_W-1:0]    a_in,
  // A element stream to the next cell.
  output mmr_pkg::tok_t                         tok_out,
  output logic [$clog2(DIM)-1:0]                k_out,
  output logic signed [mmr_pkg::VALUE_W-1:0]    a_out,
  // Result shift path toward cell zero.
  input  logic                                  shift_en,
  input  logic signed [mmr_pkg::PRODUCT_W-1:0]  acc_in,
  output logic signed [mmr_pkg::PRODUCT_W-1:0]  acc_out
);

  logic signed [mmr_pkg::VALUE_W-1:0]   b_col [DIM];
  mmr_pkg::tok_t                        prod_tok;
  logic signed [mmr_pkg::MUL_W-1:0]     prod;
  logic signed [mmr_pkg::PRODUCT_W-1:0] acc;

  // Column store of B, written by load items.
  always_ff @(posedge clk) begin
    if (b_we) begin
      b_col[b_row] <= b_value;
    end
  end

  // Register the A element on its way to the neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    k_out <= k_in;
    a_out <= a_in;
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_tok <= '0;
    end else begin
      prod_tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_in * b_col[k_in];
  end

  // Accumulate stage; the first term of a row restarts the sum. Between rows
  // the accumulators shift toward cell zero to drain the results.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      acc <= acc_in;
    end else if (prod_tok.valid) begin
      if (prod_tok.first) begin
        acc <= mmr_pkg::PRODUCT_W'(prod);
      end else begin
        acc <= acc + mmr_pkg::PRODUCT_W'(prod);
      end
    end
  end

  assign acc_out = acc;

endmodule

@@ rtl/core/matrix_multiply_row_range_unit.sv @@
// Loads are accepted while the unit is idle. A compute stalls the input until every band row
// is done; for each row the A row streams into the chain of DIM cells, the last term clears
// the chain, then the row's results shift out, one per cycle while the output is not stalled.
// Synchronous active-high reset clears control state and sets first_row to 0 and end_row to 8;
// the A and B stores hold no defined value until written.
module matrix_multiply_row_range_unit #(
  parameter int DIM = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Item channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [mmr_pkg::KIND_W-1:0]            kind,
  input  logic [mmr_pkg::ROW_W-1:0]             row,
  input  logic [mmr_pkg::ROW_W-1:0]             col,
  input  logic signed [mmr_pkg::VALUE_W-1:0]    value,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [mmr_pkg::ROW_W-1:0]             out_row,
  output logic [mmr_pkg::ROW_W-1:0]             out_col,
  output logic signed [mmr_pkg::PRODUCT_W-1:0]  product,
  output logic                                  last,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mmr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mmr_pkg::CFG_W-1:0]             cfg_data
);

  localparam int IdxW  = $clog2(DIM);
  localparam int RamD  = 1 << (2 * IdxW);
  localparam logic [mmr_pkg::CFG_W-1:0] DimC  = mmr_pkg::CFG_W'(DIM);
  localparam logic [IdxW-1:0]           LastK = IdxW'(DIM - 1);

  mmr_pkg::state_t             state, state_next;
  logic [IdxW-1:0]             row_i, row_i_next;
  logic [IdxW-1:0]             k, k_next;
  logic [IdxW-1:0]             j, j_next;
  logic [mmr_pkg::CFG_W-1:0]   hi, hi_next;
  logic [mmr_pkg::CFG_W-1:0]   first_row, end_row, hi_eff;
  logic                        band_ok, last_row;
  logic                        load_ok, load_a, load_b;
  logic                        ram_rd, shift_en, out_load, row_done;
  logic [IdxW-1:0]             feed_k;
  mmr_pkg::tok_t               feed_tok;
  logic [mmr_pkg::VALUE_W-1:0] ram_rd_data;

  mmr_pkg::tok_t                        chain_tok [DIM+1];
  logic [IdxW-1:0]                      chain_k   [DIM+1];
  logic signed [mmr_pkg::VALUE_W-1:0]   chain_a   [DIM+1];
  logic signed [mmr_pkg::PRODUCT_W-1:0] cell_acc  [DIM];

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_row <= '0;
      end_row   <= mmr_pkg::CFG_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mmr_pkg::CFG_FIRST_ROW: first_row <= cfg_data;
        mmr_pkg::CFG_END_ROW:   end_row   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Band limits: the end row saturates at DIM.
  assign hi_eff   = (end_row > DimC) ? DimC : end_row;
  assign band_ok  = hi_eff > first_row;
  assign last_row = (mmr_pkg::CFG_W'(row_i) + mmr_pkg::CFG_W'(1)) == hi;

  // Load decode; out-of-range elements are dropped.
  assign load_ok = in_valid && !in_stall
                   && ({1'b0, row} < DimC) && ({1'b0, col} < DimC);
  assign load_a  = load_ok && (kind == mmr_pkg::KIND_LOAD_A);
  assign load_b  = load_ok && (kind == mmr_pkg::KIND_LOAD_B);

  // Store of A, read one element per cycle while a row streams.
  mmr_ram #(
    .WIDTH(mmr_pkg::VALUE_W),
    .DEPTH(RamD)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (load_a),
    .wr_addr ({row[IdxW-1:0], col[IdxW-1:0]}),
    .wr_data (value),
    .rd_en   (ram_rd),
    .rd_addr ({row_i, k}),
    .rd_data (ram_rd_data)
  );

  // Tag the read data with its term index as it enters the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      feed_tok <= '0;
      row_done <= 1'b0;
    end else begin
      feed_tok.valid <= ram_rd;
      feed_tok.first <= ram_rd && (k == '0);
      feed_tok.last  <= ram_rd && (k == LastK);
      row_done       <= chain_tok[DIM].valid && chain_tok[DIM].last;
    end
  end

  always_ff @(posedge clk) begin
    feed_k <= k;
  end

  assign chain_tok[0] = feed_tok;
  assign chain_k[0]   = feed_k;
  assign chain_a[0]   = ram_rd_data;

  // Chain of multiply-accumulate cells, one per result column.
  for (genvar g = 0; g < DIM; g++) begin : g_cell
    logic signed [mmr_pkg::PRODUCT_W-1:0] shift_in;

    if (g == DIM - 1) begin : g_tail
      assign shift_in = '0;
    end else begin : g_body
      assign shift_in = cell_acc[g+1];
    end

    mmr_cell #(
      .DIM(DIM)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .b_we     (load_b && (col == mmr_pkg::ROW_W'(g))),
      .b_row    (row[IdxW-1:0]),
      .b_value  (value),
      .tok_in   (chain_tok[g]),
      .k_in     (chain_k[g]),
      .a_in     (chain_a[g]),
      .tok_out  (chain_tok[g+1]),
      .k_out    (chain_k[g+1]),
      .a_out    (chain_a[g+1]),
      .shift_en (shift_en),
      .acc_in   (shift_in),
      .acc_out  (cell_acc[g])
    );
  end

  // Sequencer state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmr_pkg::ST_IDLE;
      row_i <= '0;
      k     <= '0;
      j     <= '0;
      hi    <= '0;
    end else begin
      state <= state_next;
      row_i <= row_i_next;
      k     <= k_next;
      j     <= j_next;
      hi    <= hi_next;
    end
  end

  always_comb begin
    state_next = state;
    row_i_next = row_i;
    k_next     = k;
    j_next     = j;
    hi_next    = hi;
    in_stall   = (state != mmr_pkg::ST_IDLE);
    ram_rd     = 1'b0;
    shift_en   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      mmr_pkg::ST_IDLE: begin
        if (in_valid && (kind == mmr_pkg::KIND_COMPUTE) && band_ok) begin
          row_i_next = first_row[IdxW-1:0];
          k_next     = '0;
          hi_next    = hi_eff;
          state_next = mmr_pkg::ST_STREAM;
        end
      end
      mmr_pkg::ST_STREAM: begin
        ram_rd = 1'b1;
        if (k == LastK) begin
          state_next = mmr_pkg::ST_WAIT;
        end else begin
          k_next = k + IdxW'(1);
        end
      end
      mmr_pkg::ST_WAIT: begin
        if (row_done) begin
          j_next     = '0;
          state_next = mmr_pkg::ST_EMIT;
        end
      end
      mmr_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          shift_en = 1'b1;
          if (j == LastK) begin
            if (last_row) begin
              state_next = mmr_pkg::ST_IDLE;
            end else begin
              row_i_next = row_i + IdxW'(1);
              k_next     = '0;
              state_next = mmr_pkg::ST_STREAM;
            end
          end else begin
            j_next = j + IdxW'(1);
          end
        end
      end
      default: state_next = mmr_pkg::ST_IDLE;
    endcase
  end

  // Output register; in the emit state cell zero holds the next column's result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row <= mmr_pkg::ROW_W'(row_i);
      out_col <= mmr_pkg::ROW_W'(j);
      product <= cell_acc[0];
      last    <= last_row && (j == LastK);
    end
  end

endmodule
